### hdl/dllm_pkg.sv
// ----------------------------------------------------------------------------
// Doubly linked list manager package
// Shared constants, operation codes and controller states.
// ----------------------------------------------------------------------------
package dllm_pkg;

    localparam int NODES_DEFAULT = 64;
    localparam int NODE_W        = 6;
    localparam int OUT_IDX_W     = 7;

    typedef enum logic [1:0] {
        OP_INS_HEAD = 2'd0,
        OP_INS_TAIL = 2'd1,
        OP_UNLINK   = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

endpackage

### hdl/dllm_ram.sv
// ----------------------------------------------------------------------------
// Generic synchronous RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module dllm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hdl/doubly_linked_list_manager_unit.sv
// ----------------------------------------------------------------------------
// Doubly linked list manager
// Keeps one doubly linked list over a pool of node indices in RAM.
// ----------------------------------------------------------------------------
// Each input transaction inserts a node at the head, inserts it at the tail,
// or unlinks it, and produces one output transaction with the head, tail and
// count after the operation and an error flag for refused requests. An item
// is handled by reading the node's membership bit and links from the RAMs,
// then checking, writing back and updating head, tail and count; the update
// waits while a result is unaccepted. After reset the block clears the
// membership RAM and accepts nothing until that pass is done. The index NODES
// means no node; head, tail and count are reported in their low seven bits.
module doubly_linked_list_manager_unit #(
    parameter int NODES = dllm_pkg::NODES_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [1:0]                      op,
    input  logic [dllm_pkg::NODE_W-1:0]     node,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [dllm_pkg::NODE_W-1:0]     removed_node,
    output logic [dllm_pkg::OUT_IDX_W-1:0]  first_node,
    output logic [dllm_pkg::OUT_IDX_W-1:0]  last_node,
    output logic [dllm_pkg::OUT_IDX_W-1:0]  list_count,
    output logic                            list_empty,
    output logic                            op_error
);

    localparam int IDX_W = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int LW    = $clog2(NODES + 1);
    localparam int NW    = (IDX_W > dllm_pkg::NODE_W) ? IDX_W : dllm_pkg::NODE_W;
    localparam int WW    = (LW > dllm_pkg::OUT_IDX_W) ? LW : dllm_pkg::OUT_IDX_W;
    localparam logic [LW-1:0]    NONE     = LW'(NODES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NODES - 1);

    dllm_pkg::state_t state_reg, state_next;

    logic [1:0]                  op_reg;
    logic [dllm_pkg::NODE_W-1:0] node_reg;
    logic [IDX_W-1:0]            clr_cnt_reg, clr_cnt_next;
    logic [LW-1:0]               head_reg, head_next;
    logic [LW-1:0]               tail_reg, tail_next;
    logic [LW-1:0]               count_reg, count_next;

    logic                        out_valid_reg, out_valid_next;
    logic [dllm_pkg::NODE_W-1:0] removed_reg;
    logic [dllm_pkg::OUT_IDX_W-1:0] first_reg, last_reg, count_out_reg;
    logic                        empty_reg, error_reg;

    logic [NW-1:0]    in_wide, cur_wide;
    logic [IDX_W-1:0] in_addr, cur_addr, raddr;
    logic [LW-1:0]    cur_link;
    logic             node_ok;
    logic             accept, done, op_ok;

    logic             member;
    logic [LW-1:0]    nxt_rd, prv_rd;
    logic [LW-1:0]    prior, after;

    logic             nxt_we, prv_we, inl_we;
    logic [IDX_W-1:0] nxt_waddr, prv_waddr, inl_waddr;
    logic [LW-1:0]    nxt_wdata, prv_wdata;
    logic             inl_wdata;

    logic [WW-1:0]    head_wide, tail_wide, count_wide;

    assign in_wide  = NW'(node);
    assign cur_wide = NW'(node_reg);
    assign in_addr  = in_wide[IDX_W-1:0];
    assign cur_addr = cur_wide[IDX_W-1:0];
    assign cur_link = LW'(cur_addr);
    assign node_ok  = int'(node_reg) < NODES;
    assign raddr    = (state_reg == dllm_pkg::ST_IDLE) ? in_addr : cur_addr;

    assign in_ready = (state_reg == dllm_pkg::ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign done     = (state_reg == dllm_pkg::ST_EXEC) && (!out_valid_reg || out_ready);

    dllm_ram #(.WIDTH(LW), .DEPTH(NODES)) u_next_ram (
        .clk   (clk),
        .we    (nxt_we),
        .waddr (nxt_waddr),
        .wdata (nxt_wdata),
        .raddr (raddr),
        .rdata (nxt_rd)
    );

    dllm_ram #(.WIDTH(LW), .DEPTH(NODES)) u_prev_ram (
        .clk   (clk),
        .we    (prv_we),
        .waddr (prv_waddr),
        .wdata (prv_wdata),
        .raddr (raddr),
        .rdata (prv_rd)
    );

    dllm_ram #(.WIDTH(1), .DEPTH(NODES)) u_member_ram (
        .clk   (clk),
        .we    (inl_we),
        .waddr (inl_waddr),
        .wdata (inl_wdata),
        .raddr (raddr),
        .rdata (member)
    );

    // The head's prev and the tail's next are not always kept up to date, so the
    // unlink path substitutes "none" for them.
    assign prior = (cur_link == head_reg) ? NONE : prv_rd;
    assign after = (cur_link == tail_reg) ? NONE : nxt_rd;

    always_comb
    begin
        op_ok = 1'b0;
        if (node_ok)
        begin
            priority if (op_reg == dllm_pkg::OP_INS_HEAD || op_reg == dllm_pkg::OP_INS_TAIL)
            begin
                op_ok = !member;
            end
            else if (op_reg == dllm_pkg::OP_UNLINK)
            begin
                op_ok = member;
            end
            else
            begin
                op_ok = 1'b0;
            end
        end
    end

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        nxt_we     = 1'b0;
        nxt_waddr  = cur_addr;
        nxt_wdata  = NONE;
        prv_we     = 1'b0;
        prv_waddr  = cur_addr;
        prv_wdata  = NONE;
        inl_we     = 1'b0;
        inl_waddr  = cur_addr;
        inl_wdata  = 1'b0;

        if (state_reg == dllm_pkg::ST_CLEAR)
        begin
            inl_we    = 1'b1;
            inl_waddr = clr_cnt_reg;
        end
        else if (done && op_ok)
        begin
            inl_we = 1'b1;
            unique case (op_reg)
                dllm_pkg::OP_INS_HEAD:
                begin
                    inl_wdata  = 1'b1;
                    nxt_we     = 1'b1;
                    nxt_wdata  = head_reg;
                    prv_we     = (head_reg != NONE);
                    prv_waddr  = head_reg[IDX_W-1:0];
                    prv_wdata  = cur_link;
                    head_next  = cur_link;
                    if (head_reg == NONE)
                    begin
                        tail_next = cur_link;
                    end
                    count_next = count_reg + LW'(1);
                end
                dllm_pkg::OP_INS_TAIL:
                begin
                    inl_wdata  = 1'b1;
                    prv_we     = 1'b1;
                    prv_wdata  = tail_reg;
                    nxt_we     = (tail_reg != NONE);
                    nxt_waddr  = tail_reg[IDX_W-1:0];
                    nxt_wdata  = cur_link;
                    tail_next  = cur_link;
                    if (tail_reg == NONE)
                    begin
                        head_next = cur_link;
                    end
                    count_next = count_reg + LW'(1);
                end
                default:
                begin
                    inl_wdata  = 1'b0;
                    nxt_we     = (prior != NONE);
                    nxt_waddr  = prior[IDX_W-1:0];
                    nxt_wdata  = after;
                    prv_we     = (after != NONE);
                    prv_waddr  = after[IDX_W-1:0];
                    prv_wdata  = prior;
                    if (cur_link == head_reg)
                    begin
                        head_next = after;
                    end
                    if (cur_link == tail_reg)
                    begin
                        tail_next = prior;
                    end
                    count_next = count_reg - LW'(1);
                end
            endcase
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            dllm_pkg::ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + IDX_W'(1);
                if (clr_cnt_reg == LAST_IDX)
                begin
                    state_next = dllm_pkg::ST_IDLE;
                end
            end
            dllm_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = dllm_pkg::ST_EXEC;
                end
            end
            dllm_pkg::ST_EXEC:
            begin
                if (done)
                begin
                    state_next     = dllm_pkg::ST_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = dllm_pkg::ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dllm_pkg::ST_CLEAR;
            clr_cnt_reg   <= '0;
            head_reg      <= NONE;
            tail_reg      <= NONE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign head_wide  = WW'(head_next);
    assign tail_wide  = WW'(tail_next);
    assign count_wide = WW'(count_next);

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= op;
            node_reg <= node;
        end
        if (done)
        begin
            removed_reg   <= node_reg;
            first_reg     <= head_wide[dllm_pkg::OUT_IDX_W-1:0];
            last_reg      <= tail_wide[dllm_pkg::OUT_IDX_W-1:0];
            count_out_reg <= count_wide[dllm_pkg::OUT_IDX_W-1:0];
            empty_reg     <= (count_next == '0);
            error_reg     <= !op_ok;
        end
    end

    assign out_valid    = out_valid_reg;
    assign removed_node = removed_reg;
    assign first_node   = first_reg;
    assign last_node    = last_reg;
    assign list_count   = count_out_reg;
    assign list_empty   = empty_reg;
    assign op_error     = error_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        int'(count_reg) <= NODES)
        else $error("List count exceeds the node pool.");

    a_empty_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) == (head_reg == NONE))
        else $error("Head pointer disagrees with the list count.");

    a_ends_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        (head_reg == NONE) == (tail_reg == NONE))
        else $error("Head and tail disagree on an empty list.");

    a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == dllm_pkg::ST_EXEC)
        else $error("Accepted transaction did not enter execution.");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == dllm_pkg::ST_EXEC))
        else $error("Result appeared without an executed transaction.");

endmodule

### tb/sv/doubly_linked_list_manager_checker.sv
// ----------------------------------------------------------------------------
// Doubly linked list manager checker
// Watches both channels of the list manager and keeps its own copy of the
// list: node links, membership, head, tail and count. Every accepted request
// is applied to that copy, and the status it should report is queued. Each
// accepted result is compared field by field with the oldest queued status.
// ----------------------------------------------------------------------------
module doubly_linked_list_manager_checker #(
    parameter int NODES = dllm_pkg::NODES_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  logic [1:0]                      op,
    input  logic [dllm_pkg::NODE_W-1:0]     node,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic [dllm_pkg::NODE_W-1:0]     removed_node,
    input  logic [dllm_pkg::OUT_IDX_W-1:0]  first_node,
    input  logic [dllm_pkg::OUT_IDX_W-1:0]  last_node,
    input  logic [dllm_pkg::OUT_IDX_W-1:0]  list_count,
    input  logic                            list_empty,
    input  logic                            op_error,
    output int                              mismatches,
    output int                              outstanding
);

    localparam int IDX_W = (NODES > 1) ? $clog2(NODES) : 1;

    typedef logic [dllm_pkg::OUT_IDX_W-1:0] link_t;
    typedef logic [IDX_W-1:0]               slot_t;

    localparam link_t NO_NODE = link_t'(NODES);

    typedef struct packed {
        logic [dllm_pkg::NODE_W-1:0]    removed;
        logic [dllm_pkg::OUT_IDX_W-1:0] head;
        logic [dllm_pkg::OUT_IDX_W-1:0] tail;
        logic [dllm_pkg::OUT_IDX_W-1:0] count;
        logic                           empty;
        logic                           refused;
    } list_report_t;

    link_t        next_of [NODES];
    link_t        prev_of [NODES];
    bit           is_linked [NODES];
    link_t        head_idx;
    link_t        tail_idx;
    int unsigned  link_total;
    list_report_t expected_reports [$];

    function automatic list_report_t apply_list_request(
        input logic [1:0]                  code,
        input logic [dllm_pkg::NODE_W-1:0] idx
    );
        list_report_t rpt;
        int           n;
        slot_t        slot;
        link_t        self_link;
        link_t        prv;
        link_t        nxt;
        bit           refused;
        n         = int'(idx);
        slot      = slot_t'(idx);
        self_link = link_t'(idx);
        refused   = 1'b0;
        if (n >= NODES || (code != dllm_pkg::OP_INS_HEAD && code != dllm_pkg::OP_INS_TAIL
                           && code != dllm_pkg::OP_UNLINK))
        begin
            refused = 1'b1;
        end
        else if (code == dllm_pkg::OP_UNLINK)
        begin
            if (!is_linked[slot])
            begin
                refused = 1'b1;
            end
            else
            begin
                prv = prev_of[slot];
                nxt = next_of[slot];
                if (self_link == head_idx) head_idx = nxt;
                if (self_link == tail_idx) tail_idx = prv;
                if (int'(prv) < NODES) next_of[prv[IDX_W-1:0]] = nxt;
                if (int'(nxt) < NODES) prev_of[nxt[IDX_W-1:0]] = prv;
                prev_of[slot]   = NO_NODE;
                next_of[slot]   = NO_NODE;
                is_linked[slot] = 1'b0;
                link_total--;
            end
        end
        else if (is_linked[slot])
        begin
            refused = 1'b1;
        end
        else if (code == dllm_pkg::OP_INS_HEAD)
        begin
            next_of[slot] = head_idx;
            prev_of[slot] = NO_NODE;
            if (link_total == 0) tail_idx = self_link;
            else prev_of[head_idx[IDX_W-1:0]] = self_link;
            head_idx = self_link;
            is_linked[slot] = 1'b1;
            link_total++;
        end
        else
        begin
            prev_of[slot] = tail_idx;
            next_of[slot] = NO_NODE;
            if (link_total == 0) head_idx = self_link;
            else next_of[tail_idx[IDX_W-1:0]] = self_link;
            tail_idx = self_link;
            is_linked[slot] = 1'b1;
            link_total++;
        end
        rpt.removed = idx;
        rpt.head    = head_idx;
        rpt.tail    = tail_idx;
        rpt.count   = link_total[dllm_pkg::OUT_IDX_W-1:0];
        rpt.empty   = (link_total == 0);
        rpt.refused = refused;
        return rpt;
    endfunction

    task automatic check_field(input string label, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        list_report_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < NODES; i++)
            begin
                next_of[i]   = NO_NODE;
                prev_of[i]   = NO_NODE;
                is_linked[i] = 1'b0;
            end
            head_idx    = NO_NODE;
            tail_idx    = NO_NODE;
            link_total  = 0;
            mismatches  = 0;
            expected_reports.delete();
            outstanding = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_reports.size() == 0)
                begin
                    mismatches++;
                    $display({"%0t: unexpected result transaction, expected none, ",
                              "actual node %0d head %0d tail %0d count %0d"},
                             $time, removed_node, first_node, last_node, list_count);
                end
                else
                begin
                    want = expected_reports.pop_front();
                    check_field("removed_node", 32'(want.removed), 32'(removed_node));
                    check_field("first_node", 32'(want.head), 32'(first_node));
                    check_field("last_node", 32'(want.tail), 32'(last_node));
                    check_field("list_count", 32'(want.count), 32'(list_count));
                    check_field("list_empty", 32'(want.empty), 32'(list_empty));
                    check_field("op_error", 32'(want.refused), 32'(op_error));
                end
            end
            if (in_valid && in_ready)
            begin
                expected_reports.push_back(apply_list_request(op, node));
            end
            outstanding = expected_reports.size();
        end
    end

endmodule

### tb/sv/tb_doubly_linked_list_manager_unit.sv
// ----------------------------------------------------------------------------
// Doubly linked list manager testbench
// Drives insert and unlink requests into the list manager, first a directed
// walk through empty, single node, head, tail and middle cases and refused
// requests, then random sequences that mostly grow and shrink the list
// toward changing fill goals. Sender gaps and receiver stalls vary by phase.
// ----------------------------------------------------------------------------
module tb_doubly_linked_list_manager_unit;

    localparam int         NODES          = dllm_pkg::NODES_DEFAULT;
    localparam logic [1:0] OP_UNUSED      = 2'd3;
    localparam int         RANDOM_ITEMS   = 1650;
    localparam int         PHASES         = 4;
    localparam int         LONG_HOLD      = 300;
    localparam int         WATCHDOG_LIMIT = 4000;
    localparam int         DRAIN_CYCLES   = 8;

    typedef logic [dllm_pkg::NODE_W-1:0] node_idx_t;

    logic                            clk;
    logic                            rst_n;
    logic                            in_valid;
    logic                            in_ready;
    logic [1:0]                      op;
    logic [dllm_pkg::NODE_W-1:0]     node;
    logic                            out_valid;
    logic                            out_ready;
    logic [dllm_pkg::NODE_W-1:0]     removed_node;
    logic [dllm_pkg::OUT_IDX_W-1:0]  first_node;
    logic [dllm_pkg::OUT_IDX_W-1:0]  last_node;
    logic [dllm_pkg::OUT_IDX_W-1:0]  list_count;
    logic                            list_empty;
    logic                            op_error;

    int mismatches;
    int outstanding;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_requests;
    int holds_served;
    int quiet_cycles = 0;
    bit stim_linked [NODES];
    int stim_linked_total;
    int fill_goal;

    int idle_by_phase  [PHASES] = '{0, 62, 0, 26};
    int stall_by_phase [PHASES] = '{0, 0, 62, 26};

    doubly_linked_list_manager_unit #(
        .NODES(NODES)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .node        (node),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .removed_node(removed_node),
        .first_node  (first_node),
        .last_node   (last_node),
        .list_count  (list_count),
        .list_empty  (list_empty),
        .op_error    (op_error)
    );

    doubly_linked_list_manager_checker #(
        .NODES(NODES)
    ) list_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .node        (node),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .removed_node(removed_node),
        .first_node  (first_node),
        .last_node   (last_node),
        .list_count  (list_count),
        .list_empty  (list_empty),
        .op_error    (op_error),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        out_ready = 1'b0;
        holds_served = 0;
        forever
        begin
            @(negedge clk);
            if (hold_requests != holds_served)
            begin
                holds_served++;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic send_request(input logic [1:0] code, input node_idx_t idx);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        op       <= code;
        node     <= idx;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
        if (code == dllm_pkg::OP_UNLINK && stim_linked[idx])
        begin
            stim_linked[idx] = 1'b0;
            stim_linked_total--;
        end
        else if ((code == dllm_pkg::OP_INS_HEAD || code == dllm_pkg::OP_INS_TAIL)
                 && !stim_linked[idx])
        begin
            stim_linked[idx] = 1'b1;
            stim_linked_total++;
        end
    endtask

    task automatic pick_request(output logic [1:0] code, output node_idx_t idx);
        bit grow;
        if ($urandom_range(99) < 12)
        begin
            code = 2'($urandom_range(3));
            idx  = node_idx_t'($urandom_range(NODES - 1));
        end
        else
        begin
            if (stim_linked_total < fill_goal) grow = ($urandom_range(99) < 80);
            else grow = ($urandom_range(99) < 20);
            if (stim_linked_total == 0) grow = 1'b1;
            if (stim_linked_total == NODES) grow = 1'b0;
            if (grow)
            begin
                do idx = node_idx_t'($urandom_range(NODES - 1)); while (stim_linked[idx]);
                code = ($urandom_range(1) == 0) ? dllm_pkg::OP_INS_HEAD
                                                : dllm_pkg::OP_INS_TAIL;
            end
            else
            begin
                do idx = node_idx_t'($urandom_range(NODES - 1)); while (!stim_linked[idx]);
                code = dllm_pkg::OP_UNLINK;
            end
        end
    endtask

    initial
    begin
        logic [1:0] code;
        node_idx_t  idx;
        int         per_phase;
        rst_n             = 1'b0;
        in_valid          = 1'b0;
        op                = dllm_pkg::OP_INS_HEAD;
        node              = '0;
        send_idle_pct     = 0;
        recv_stall_pct    = 0;
        hold_requests     = 0;
        stim_linked_total = 0;
        fill_goal         = 0;
        for (int i = 0; i < NODES; i++) stim_linked[i] = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_request(dllm_pkg::OP_UNLINK, 6'd0);
        send_request(dllm_pkg::OP_INS_HEAD, 6'd0);
        send_request(dllm_pkg::OP_INS_HEAD, 6'd63);
        send_request(dllm_pkg::OP_INS_TAIL, 6'd1);
        send_request(dllm_pkg::OP_INS_TAIL, 6'd62);
        send_request(dllm_pkg::OP_INS_HEAD, 6'd0);
        send_request(dllm_pkg::OP_INS_TAIL, 6'd63);
        send_request(dllm_pkg::OP_UNLINK, 6'd0);
        send_request(dllm_pkg::OP_UNLINK, 6'd63);
        send_request(dllm_pkg::OP_UNLINK, 6'd62);
        send_request(dllm_pkg::OP_UNLINK, 6'd1);
        send_request(dllm_pkg::OP_UNLINK, 6'd1);
        send_request(OP_UNUSED, 6'd5);
        send_request(OP_UNUSED, 6'd63);
        send_request(dllm_pkg::OP_INS_TAIL, 6'd42);
        send_request(OP_UNUSED, 6'd42);
        send_request(dllm_pkg::OP_INS_HEAD, 6'd21);
        send_request(dllm_pkg::OP_UNLINK, 6'd42);
        send_request(dllm_pkg::OP_UNLINK, 6'd21);
        send_request(dllm_pkg::OP_INS_HEAD, 6'd7);
        send_request(dllm_pkg::OP_INS_TAIL, 6'd56);

        per_phase = RANDOM_ITEMS / PHASES;
        for (int phase = 0; phase < PHASES; phase++)
        begin
            send_idle_pct  = idle_by_phase[phase];
            recv_stall_pct = stall_by_phase[phase];
            for (int k = 0; k < per_phase; k++)
            begin
                if (k % 80 == 0)
                begin
                    case ($urandom_range(2))
                        0: fill_goal = 0;
                        1: fill_goal = NODES;
                        default: fill_goal = $urandom_range(1, NODES - 1);
                    endcase
                end
                if (phase == 0 && k == 150) hold_requests++;
                pick_request(code, idx);
                send_request(code, idx);
            end
            in_valid <= 1'b0;
            wait (outstanding == 0);
            @(negedge clk);
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

### filelist.f
hdl/dllm_pkg.sv
hdl/dllm_ram.sv
hdl/doubly_linked_list_manager_unit.sv
tb/sv/doubly_linked_list_manager_checker.sv
tb/sv/tb_doubly_linked_list_manager_unit.sv
